@@ rtl/mts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack package
// Shared sizes, action codes and status codes of the min-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int DEPTH_W     = 11;

  localparam logic [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};

  // Action codes of an input beat. Any other code only reports.
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_NOP  = 2'd2;

  // Status codes of a result beat.
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FILL = 2'b10
  } state_t;

endpackage

@@ rtl/mts_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack request channel
// Valid/ready channel that carries one stack action per beat.
// ----------------------------------------------------------------------------
interface mts_req_if
  import mts_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

@@ rtl/mts_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack response channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
interface mts_rsp_if
  import mts_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] min_value;
  logic [DEPTH_W-1:0]       depth;
  logic [1:0]               status;

  modport source (output valid, output top_value, output min_value, output depth,
                  output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input depth,
                  input status, output ready);
endinterface

@@ rtl/min_tracking_stack_top.sv @@
`timescale 1ns / 1ps
// A push, a no-op or a refused action shows its result in the cycle after its beat.
// A pop that removes an element waits in the refill state for the RAM reads first.
// Throughput: one beat per cycle for pushes and no-ops while results drain; a pop holds the
// block until the read of both RAMs has refilled the cached stack tops.
// Reset clears the state, both counts and the output valid flag; the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
// Min-tracking stack top level
// A stack of signed values in one RAM, with a second RAM that holds the chain of
// running minimums. The current tops of both stacks are cached in registers.
// ----------------------------------------------------------------------------
module min_tracking_stack_top
  import mts_pkg::*;
(
  input logic       clk,
  input logic       rst,
  mts_req_if.sink   req,
  mts_rsp_if.source rsp
);

  // Control state and counts.
  state_t           state, state_next;
  logic [CNT_W-1:0] vc, vc_next;
  logic [CNT_W-1:0] mc, mc_next;

  // Cached tops of the value stack and of the minimum stack. They are only
  // meaningful while the matching count is nonzero.
  logic signed [DATA_W-1:0] top, top_next;
  logic signed [DATA_W-1:0] mtop, mtop_next;

  // Output register.
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_top;
  logic signed [DATA_W-1:0] out_min;
  logic [DEPTH_W-1:0]       out_depth;
  logic [1:0]               out_status;

  logic       accept;
  logic       emit;
  logic [1:0] status_next;

  // RAM ports.
  logic              val_we, min_we, rd_en;
  logic [ADDR_W-1:0] val_waddr, min_waddr, val_raddr, min_raddr;
  logic [DATA_W-1:0] val_rdata, min_rdata;
  logic [CNT_W-1:0]  val_ridx, min_ridx;
  logic              push_ok, pop_ok, min_drop;

  // A new beat is taken only between items, and only when the output register
  // is empty or drains in this cycle, so a result never waits for a free slot.
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // A push goes to the value stack when there is room. It also goes to the
  // minimum stack when that stack is empty or the value does not exceed its
  // top; the minimum stack never holds more than the value stack.
  assign push_ok = accept && (req.action == ACT_PUSH) && (vc != CNT_W'(STACK_DEPTH));
  assign val_we  = push_ok;
  assign min_we  = push_ok && ((mc == '0) || (req.value <= mtop));

  assign val_waddr = vc[ADDR_W-1:0];
  assign min_waddr = mc[ADDR_W-1:0];

  // A pop on a nonempty stack drops the minimum top too when it equals the
  // popped value. Both new tops are then read back from the RAMs; when a count
  // falls to zero the read returns an entry that is never reported.
  assign pop_ok   = accept && (req.action == ACT_POP) && (vc != '0);
  assign min_drop = pop_ok && (top == mtop);
  assign rd_en    = pop_ok;
  assign val_ridx = vc - CNT_W'(2);
  assign min_ridx = mc - (min_drop ? CNT_W'(2) : CNT_W'(1));
  assign val_raddr = val_ridx[ADDR_W-1:0];
  assign min_raddr = min_ridx[ADDR_W-1:0];

  mts_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DATA_W)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (req.value),
    .re    (rd_en),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  mts_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DATA_W)
  ) u_minimum_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (min_waddr),
    .wdata (req.value),
    .re    (rd_en),
    .raddr (min_raddr),
    .rdata (min_rdata)
  );

  always_comb begin
    state_next  = state;
    vc_next     = vc;
    mc_next     = mc;
    top_next    = top;
    mtop_next   = mtop;
    status_next = STATUS_DONE;
    emit        = 1'b0;
    if (state == S_FILL) begin
      // The RAM reads issued by the pop have landed: refresh the cached tops.
      top_next   = val_rdata;
      mtop_next  = min_rdata;
      emit       = 1'b1;
      state_next = S_IDLE;
    end else if (accept) begin
      priority if (req.action == ACT_PUSH) begin
        emit = 1'b1;
        if (push_ok) begin
          vc_next  = vc + CNT_W'(1);
          top_next = req.value;
          if (min_we) begin
            mc_next   = mc + CNT_W'(1);
            mtop_next = req.value;
          end
        end else begin
          status_next = STATUS_FULL;
        end
      end else if (req.action == ACT_POP) begin
        if (pop_ok) begin
          vc_next    = vc - CNT_W'(1);
          mc_next    = min_drop ? mc - CNT_W'(1) : mc;
          state_next = S_FILL;
        end else begin
          emit        = 1'b1;
          status_next = STATUS_EMPTY;
        end
      end else begin
        // A no-op, or the unused action code, only reports the state.
        emit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vc        <= '0;
      mc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      vc        <= vc_next;
      mc        <= mc_next;
      out_valid <= emit || (out_valid && !rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    top  <= top_next;
    mtop <= mtop_next;
    if (emit) begin
      out_top    <= (vc_next == '0) ? MOST_NEGATIVE : top_next;
      out_min    <= (mc_next == '0) ? MOST_NEGATIVE : mtop_next;
      out_depth  <= DEPTH_W'(vc_next);
      out_status <= status_next;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.top_value = out_top;
  assign rsp.min_value = out_min;
  assign rsp.depth     = out_depth;
  assign rsp.status    = out_status;

endmodule

@@ rtl/mts_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ dv/tb_min_tracking_stack_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-tracking stack testbench
// Drives push, pop and no-op beats into the stack, predicts every result with
// a shadow copy of both stacks, and checks each result beat field by field.
// ----------------------------------------------------------------------------
module tb_min_tracking_stack_top
  import mts_pkg::*;
();

  // The action code that the package leaves unnamed. The block treats it as a no-op.
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam logic signed [DATA_W-1:0] LOWEST  = MOST_NEGATIVE;
  localparam logic signed [DATA_W-1:0] HIGHEST = ~MOST_NEGATIVE;

  // The slowest correct run stays far below this. Every beat can cost a full send
  // gap, a pop's refill and a full receive stall, and there are a few thousand.
  localparam int unsigned CYCLE_LIMIT = 500_000;

  typedef struct {
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic [DEPTH_W-1:0]       depth;
    logic [1:0]               status;
  } stack_report_t;

  logic clk = 1'b0;
  logic rst;

  mts_req_if req_ch();
  mts_rsp_if rsp_ch();

  min_tracking_stack_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the stack. The second array holds the chain of running minimums:
  // a push joins the chain when it is at or below the chain's top, and a pop leaves
  // the chain when the popped value equals the chain's top.
  logic signed [DATA_W-1:0] shadow_vals [STACK_DEPTH];
  logic signed [DATA_W-1:0] shadow_mins [STACK_DEPTH];
  int shadow_count     = 0;
  int shadow_min_count = 0;

  // Results still owed by the block, oldest first.
  stack_report_t pending_reports[$];

  int fail_count      = 0;
  int req_gap_max     = 0;
  int rsp_gap_max     = 0;
  int rsp_hold_cycles = 0;
  int beat_serial     = 0;
  int unsigned cycle_count = 0;

  function automatic logic signed [DATA_W-1:0] shadow_top();
    return (shadow_count > 0) ? shadow_vals[shadow_count - 1] : LOWEST;
  endfunction

  function automatic logic signed [DATA_W-1:0] shadow_min();
    return (shadow_min_count > 0) ? shadow_mins[shadow_min_count - 1] : LOWEST;
  endfunction

  // Applies one accepted beat to the shadow stacks and returns the report the
  // block must give for it.
  function automatic stack_report_t apply_stack_action(logic [1:0] action,
                                                       logic signed [DATA_W-1:0] value);
    stack_report_t rep;
    rep.status = STATUS_DONE;
    if (action == ACT_PUSH) begin
      if (shadow_count >= STACK_DEPTH) begin
        rep.status = STATUS_FULL;
      end else begin
        if (shadow_min_count == 0 || value <= shadow_min()) begin
          if (shadow_min_count < STACK_DEPTH) begin
            shadow_mins[shadow_min_count] = value;
            shadow_min_count++;
          end
        end
        shadow_vals[shadow_count] = value;
        shadow_count++;
      end
    end else if (action == ACT_POP) begin
      if (shadow_count == 0) begin
        rep.status = STATUS_EMPTY;
      end else begin
        if (shadow_min_count > 0 && shadow_top() == shadow_min()) begin
          shadow_min_count--;
        end
        shadow_count--;
      end
    end
    rep.top_value = shadow_top();
    rep.min_value = shadow_min();
    rep.depth     = DEPTH_W'(shadow_count);
    return rep;
  endfunction

  // Offers one beat after a random gap and waits for the handshake. Valid stays
  // high on return, so a following beat with no gap goes out back to back.
  task automatic send_beat(logic [1:0] action, logic signed [DATA_W-1:0] value);
    int gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= action;
    req_ch.value  <= value;
    do @(posedge clk); while (!req_ch.ready);
    pending_reports.push_back(apply_stack_action(action, value));
  endtask

  // Stops offering and waits until the block has returned every owed result.
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Push values are drawn from classes that stress the minimum chain: values
  // equal to the current minimum, new minimums just below it, and the extremes.
  function automatic logic signed [DATA_W-1:0] pick_push_value();
    logic signed [DATA_W-1:0] m;
    m = shadow_min();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 16) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0: return HIGHEST;
          1: return LOWEST;
          2: return -1;
          default: return 0;
        endcase
      end
      3: return (shadow_count > 0) ? m : $urandom;
      4: return (m > LOWEST + 3) ? m - DATA_W'($urandom_range(0, 3)) : LOWEST;
      default: return shadow_top() + DATA_W'($urandom_range(0, 7)) - 3;
    endcase
  endfunction

  // One random beat with the given weights in percent. Whatever is left over goes
  // to the two report-only codes. The idle ceilings of both sides change every 64
  // beats, so that some stretches run with no gaps at all.
  task automatic random_beat(int push_pct, int pop_pct);
    int r;
    if (beat_serial % 64 == 0) begin
      req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
      rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
    end
    beat_serial++;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      send_beat(ACT_PUSH, pick_push_value());
    else if (r < push_pct + pop_pct)
      send_beat(ACT_POP, $urandom);
    else
      send_beat($urandom_range(0, 1) ? ACT_NOP : ACT_SPARE, $urandom);
  endtask

  // Empty-stack reports, every action code, both value extremes, and minimums that
  // repeat so that only the matching pop may retire them from the chain.
  task automatic test_directed();
    req_gap_max = 16;
    rsp_gap_max = 16;
    send_beat(ACT_NOP, 32'sd0);
    send_beat(ACT_POP, 32'sd0);
    send_beat(ACT_SPARE, -32'sd1);
    send_beat(ACT_PUSH, HIGHEST);
    send_beat(ACT_PUSH, LOWEST);
    send_beat(ACT_PUSH, LOWEST);
    send_beat(ACT_PUSH, 32'sd0);
    send_beat(ACT_PUSH, -32'sd1);
    send_beat(ACT_NOP, 32'sh5555_5555);
    send_beat(ACT_POP, 32'sd0);
    send_beat(ACT_POP, -32'sd1);
    send_beat(ACT_POP, 32'sd0);
    send_beat(ACT_SPARE, 32'sh2AAA_AAAA);
    send_beat(ACT_POP, 32'sd0);
    send_beat(ACT_POP, 32'sd0);
    send_beat(ACT_POP, 32'sd0);
    send_beat(ACT_PUSH, 32'sd3);
    send_beat(ACT_PUSH, 32'sd3);
    send_beat(ACT_PUSH, 32'sd4);
    send_beat(ACT_POP, 32'sd0);
    send_beat(ACT_POP, 32'sd0);
    send_beat(ACT_NOP, 32'sd0);
    send_beat(ACT_POP, 32'sd0);
    wait_for_drain();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // back to back, so the block's output fills and it must stall its input.
  task automatic test_backpressure();
    req_gap_max = 0;
    rsp_gap_max = 0;
    rsp_hold_cycles = 250;
    repeat (30) send_beat(ACT_PUSH, pick_push_value());
    repeat (10) send_beat(ACT_POP, $urandom);
    wait_for_drain();
  endtask

  // Balanced traffic around a shallow stack, with frequent pops on an empty one.
  task automatic test_random_mix();
    repeat (150) random_beat(40, 40);
    wait_for_drain();
  endtask

  // Grows the stack to its full depth, tries refused pushes there, then pops it
  // all the way down and past empty.
  task automatic test_fill_and_drain();
    while (shadow_count < STACK_DEPTH) random_beat(92, 4);
    repeat (3) send_beat(ACT_PUSH, $urandom);
    send_beat(ACT_NOP, $urandom);
    while (shadow_count > 0) random_beat(4, 92);
    repeat (2) send_beat(ACT_POP, $urandom);
    wait_for_drain();
  endtask

  // Result side. Each beat draws the stall before the next one; a requested hold
  // takes precedence and is counted down here, one cycle per edge.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) stall_left = $urandom_range(0, rsp_gap_max);
      if (rsp_hold_cycles > 0) begin
        rsp_hold_cycles--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Every accepted result must match the oldest owed report in all four fields.
  always @(posedge clk) begin : result_check
    stack_report_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result beat: top_value %0d, depth %0d",
               rsp_ch.top_value, rsp_ch.depth);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (rsp_ch.top_value !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", want.top_value, rsp_ch.top_value);
          fail_count++;
        end
        if (rsp_ch.min_value !== want.min_value) begin
          $error("min_value: expected %0d, got %0d", want.min_value, rsp_ch.min_value);
          fail_count++;
        end
        if (rsp_ch.depth !== want.depth) begin
          $error("depth: expected %0d, got %0d", want.depth, rsp_ch.depth);
          fail_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          fail_count++;
        end
      end
    end
  end

  // A hang anywhere ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst           <= 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_NOP;
    req_ch.value  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random_mix();
    test_fill_and_drain();

    // Any stray result after the last drain would be caught by the checker here.
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_reports.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ min_tracking_stack_top.f @@
rtl/mts_pkg.sv
rtl/mts_req_if.sv
rtl/mts_rsp_if.sv
rtl/mts_ram.sv
rtl/min_tracking_stack_top.sv
dv/tb_min_tracking_stack_top.sv
